// ===== design/ptdr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptdr_pkg
// Shared types and codes for the per-thread descriptor ring.
// ----------------------------------------------------------------------------
package ptdr_pkg;

  localparam int THREAD_W = 2;
  localparam int LEN_W    = 16;
  localparam int DATA_W   = 32;
  localparam int SLOT_W   = 6;

  typedef enum logic [1:0] {
    FN_RESERVE = 2'd0,
    FN_PUSH    = 2'd1,
    FN_PULL    = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_BAD_STATE = 2'd1,
    STS_NO_SLOT   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    DS_FREE     = 2'd0,
    DS_RESERVED = 2'd1,
    DS_FILLED   = 2'd2
  } dstate_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_PULL
  } fsm_t;

  // pointer advance request from the sequencer to the pointer file
  typedef struct packed {
    logic                adv;
    func_t               sel;
    logic [THREAD_W-1:0] thread;
  } ptr_cmd_t;

endpackage

// ===== design/per_thread_descriptor_ring_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_thread_descriptor_ring_top
// Descriptor ring split into per-thread segments with a packet pool in two source halves, each with a share per thread.
//
// Input channel (in_*): one request per transfer: reserve, push or pull on
// the segment of in_thread. Result channel (out_*): exactly one result per
// request, in request order.
// A result is formed in the evaluation state from the registered descriptor and
// occupancy reads and loaded into the output register. A pull that returns a
// packet also passes through the pull state, since the pool slot address comes
// from the descriptor read. One request is worked on at a time, so the block
// takes a new request only once the last one's result is loaded; the bound is
// the read-modify-write through the descriptor, occupancy and pool RAMs.
// A finished result waits in the output register while the next request is
// taken; if that register is still full when the next result is ready, the
// sequencer holds until out_ready frees it.
// Reset: a clearing pass over all THREADS*SLOTS_PER_THREAD descriptor addresses
// sweeps the descriptor RAM (all free) and the slot occupancy RAM (all empty);
// in_ready stays low during the pass.
// ----------------------------------------------------------------------------
module per_thread_descriptor_ring_top
  import ptdr_pkg::*;
#(
  parameter int THREADS          = 4,
  parameter int SLOTS_PER_THREAD = 8,
  parameter int PAYLOAD_BITS     = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_func,
  input  logic [THREAD_W-1:0] in_thread,
  input  logic                in_source,
  input  logic [LEN_W-1:0]    in_packet_len,
  input  logic [DATA_W-1:0]   in_packet_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output logic [LEN_W-1:0]    out_len,
  output logic [DATA_W-1:0]   out_data,
  output logic [SLOT_W-1:0]   out_slot_used
);

  localparam int RING   = THREADS * SLOTS_PER_THREAD;
  localparam int POOL   = 2 * RING;
  localparam int ROWS   = 2 * THREADS;
  localparam int OFW    = $clog2(SLOTS_PER_THREAD);
  localparam int RW     = $clog2(RING);
  localparam int PIW    = $clog2(POOL);
  localparam int OW     = $clog2(ROWS);
  localparam int DESC_W = 3 + OFW;
  localparam int POOL_W = LEN_W + PAYLOAD_BITS;

  // sequencer
  fsm_t state_r, state_nxt;
  logic [RW-1:0] clr_r;
  logic in_fire;
  logic out_ok;

  // request latch
  logic [1:0]          req_func_r;
  logic [THREAD_W-1:0] req_thread_r;
  logic                req_src_r;
  logic [LEN_W-1:0]    req_len_r;
  logic [DATA_W-1:0]   req_data_r;
  logic [OFW-1:0]      req_off_r;
  logic                thr_ok_r;
  logic [PIW-1:0]      pull_idx_r;
  logic [OW-1:0]       pull_row_r;
  logic [OFW-1:0]      pull_off_r;

  // accept-side address generation
  logic                thr_ok_in;
  logic [THREAD_W-1:0] thr_in;
  logic [OFW-1:0]      rd_off;
  logic [RW-1:0]       acc_desc_addr;
  logic [OW-1:0]       acc_row;

  // memories
  logic                desc_we;
  logic [RW-1:0]       desc_waddr;
  logic [DESC_W-1:0]   desc_wdata;
  logic [DESC_W-1:0]   desc_rd;
  logic                occ_we;
  logic [OW-1:0]       occ_waddr;
  logic [SLOTS_PER_THREAD-1:0] occ_wdata;
  logic                occ_re;
  logic                occ_re_pull;
  logic [OW-1:0]       occ_raddr;
  logic [SLOTS_PER_THREAD-1:0] occ_rd;
  logic                pool_we;
  logic                pool_re;
  logic [POOL_W-1:0]   pool_rd;

  // evaluation
  dstate_t             dst;
  logic                dsrc;
  logic [OFW-1:0]      doff;
  logic [RW-1:0]       d_addr;
  logic                hit;
  logic [OFW-1:0]      free_off;
  logic [PIW-1:0]      push_idx;
  logic [OW-1:0]       push_row;
  logic [PIW-1:0]      pull_idx;
  logic [OW-1:0]       pull_row;
  logic [SLOTS_PER_THREAD-1:0] set_mask;
  logic [SLOTS_PER_THREAD-1:0] clr_mask;
  logic                pull_go;
  ptr_cmd_t            ptr_cmd;

  // result
  logic                res_load;
  status_t             res_status;
  logic [LEN_W-1:0]    res_len;
  logic [DATA_W-1:0]   res_data;
  logic [PIW-1:0]      res_slot;
  logic                out_valid_r;
  status_t             out_status_r;
  logic [LEN_W-1:0]    out_len_r;
  logic [DATA_W-1:0]   out_data_r;
  logic [SLOT_W-1:0]   out_slot_r;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_ok   = !out_valid_r || out_ready;

  assign thr_ok_in     = int'(in_thread) < THREADS;
  assign thr_in        = thr_ok_in ? in_thread : '0;
  assign acc_desc_addr = RW'(int'(thr_in) * SLOTS_PER_THREAD + int'(rd_off));
  assign acc_row       = OW'(int'(in_source) * THREADS + int'(thr_in));

  ptdr_ptr_file #(
    .THREADS          (THREADS),
    .SLOTS_PER_THREAD (SLOTS_PER_THREAD)
  ) u_ptrs (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_thread (in_thread),
    .rd_sel    (func_t'(in_func)),
    .rd_off    (rd_off),
    .cmd       (ptr_cmd)
  );

  ptdr_ram #(.WIDTH(DESC_W), .DEPTH(RING)) u_desc_ram (
    .clk     (clk),
    .we      (desc_we),
    .waddr   (desc_waddr),
    .wdata   (desc_wdata),
    .re      (in_fire),
    .raddr   (acc_desc_addr),
    .rd_data (desc_rd)
  );

  // one bit per pool slot: set while the slot holds a nonzero length
  assign occ_re    = in_fire || occ_re_pull;
  assign occ_raddr = (state_r == S_EVAL) ? pull_row : acc_row;

  ptdr_ram #(.WIDTH(SLOTS_PER_THREAD), .DEPTH(ROWS)) u_occ_ram (
    .clk     (clk),
    .we      (occ_we),
    .waddr   (occ_waddr),
    .wdata   (occ_wdata),
    .re      (occ_re),
    .raddr   (occ_raddr),
    .rd_data (occ_rd)
  );

  ptdr_ram #(.WIDTH(POOL_W), .DEPTH(POOL)) u_pool_ram (
    .clk     (clk),
    .we      (pool_we),
    .waddr   (push_idx),
    .wdata   ({req_len_r, PAYLOAD_BITS'(req_data_r)}),
    .re      (pool_re),
    .raddr   (pull_idx),
    .rd_data (pool_rd)
  );

  // descriptor fields and derived addresses
  assign dst      = dstate_t'(desc_rd[DESC_W-1 -: 2]);
  assign dsrc     = desc_rd[OFW];
  assign doff     = desc_rd[OFW-1:0];
  assign d_addr   = RW'(int'(req_thread_r) * SLOTS_PER_THREAD + int'(req_off_r));
  assign push_row = OW'(int'(req_src_r) * THREADS + int'(req_thread_r));
  assign pull_row = OW'(int'(dsrc) * THREADS + int'(req_thread_r));
  assign push_idx = PIW'(int'(req_src_r) * RING + int'(req_thread_r) * SLOTS_PER_THREAD
                         + int'(free_off));
  assign pull_idx = PIW'(int'(dsrc) * RING + int'(req_thread_r) * SLOTS_PER_THREAD
                         + int'(doff));

  // first empty slot, lowest index wins
  always_comb begin
    hit      = 1'b0;
    free_off = '0;
    for (int i = SLOTS_PER_THREAD - 1; i >= 0; i--) begin
      if (!occ_rd[i]) begin
        hit      = 1'b1;
        free_off = OFW'(i);
      end
    end
  end

  always_comb begin
    set_mask           = '0;
    set_mask[free_off] = (req_len_r != '0);
    clr_mask           = '0;
    clr_mask[pull_off_r] = 1'b1;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == RW'(RING - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (in_fire) state_nxt = S_EVAL;
      S_EVAL: begin
        if (pull_go) begin
          state_nxt = S_PULL;
        end else if (out_ok) begin
          state_nxt = S_IDLE;
        end
      end
      S_PULL:  if (out_ok) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // memory writes, pointer updates and result
  always_comb begin
    desc_we      = 1'b0;
    desc_waddr   = d_addr;
    desc_wdata   = '0;
    occ_we       = 1'b0;
    occ_waddr    = push_row;
    occ_wdata    = occ_rd;
    occ_re_pull  = 1'b0;
    pool_we      = 1'b0;
    pool_re      = 1'b0;
    pull_go      = 1'b0;
    ptr_cmd.adv    = 1'b0;
    ptr_cmd.sel    = FN_RESERVE;
    ptr_cmd.thread = req_thread_r;
    res_load     = 1'b0;
    res_status   = STS_BAD_STATE;
    res_len      = '0;
    res_data     = '0;
    res_slot     = '0;
    case (state_r)
      S_CLEAR: begin
        desc_we    = 1'b1;
        desc_waddr = clr_r;
        desc_wdata = {DS_FREE, {(DESC_W-2){1'b0}}};
        if (int'(clr_r) < ROWS) begin
          occ_we    = 1'b1;
          occ_waddr = OW'(clr_r);
          occ_wdata = '0;
        end
      end
      S_EVAL: begin
        if (thr_ok_r && req_func_r == FN_PULL && dst == DS_FILLED) begin
          // free the descriptor now, fetch the packet for the next cycle
          desc_we     = 1'b1;
          desc_wdata  = {DS_FREE, {(DESC_W-2){1'b0}}};
          ptr_cmd.adv = 1'b1;
          ptr_cmd.sel = FN_PULL;
          pool_re     = 1'b1;
          occ_re_pull = 1'b1;
          pull_go     = 1'b1;
        end else if (out_ok) begin
          res_load = 1'b1;
          if (thr_ok_r) begin
            case (func_t'(req_func_r))
              FN_RESERVE: begin
                if (dst == DS_FREE) begin
                  desc_we     = 1'b1;
                  desc_wdata  = {DS_RESERVED, {(DESC_W-2){1'b0}}};
                  ptr_cmd.adv = 1'b1;
                  ptr_cmd.sel = FN_RESERVE;
                  res_status  = STS_OK;
                end
              end
              FN_PUSH: begin
                if (dst == DS_RESERVED) begin
                  if (hit) begin
                    pool_we     = 1'b1;
                    occ_we      = 1'b1;
                    occ_wdata   = occ_rd | set_mask;
                    desc_we     = 1'b1;
                    desc_wdata  = {DS_FILLED, req_src_r, free_off};
                    ptr_cmd.adv = 1'b1;
                    ptr_cmd.sel = FN_PUSH;
                    res_status  = STS_OK;
                    res_slot    = push_idx;
                  end else begin
                    res_status = STS_NO_SLOT;
                  end
                end
              end
              default: ;
            endcase
          end
        end
      end
      S_PULL: begin
        if (out_ok) begin
          occ_we     = 1'b1;
          occ_waddr  = pull_row_r;
          occ_wdata  = occ_rd & ~clr_mask;
          res_load   = 1'b1;
          res_status = STS_OK;
          // a slot already pulled reads as zero length; the RAM keeps the old one
          res_len    = occ_rd[pull_off_r] ? pool_rd[POOL_W-1 -: LEN_W] : '0;
          res_data   = DATA_W'(pool_rd[PAYLOAD_BITS-1:0]);
          res_slot   = pull_idx_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_func_r   <= in_func;
      req_thread_r <= in_thread;
      req_src_r    <= in_source;
      req_len_r    <= in_packet_len;
      req_data_r   <= in_packet_data;
      req_off_r    <= rd_off;
      thr_ok_r     <= thr_ok_in;
    end
    if (pull_go) begin
      pull_idx_r <= pull_idx;
      pull_row_r <= pull_row;
      pull_off_r <= doff;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status_r <= res_status;
      out_len_r    <= res_len;
      out_data_r   <= res_data;
      out_slot_r   <= SLOT_W'(res_slot);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_len       = out_len_r;
  assign out_data      = out_data_r;
  assign out_slot_used = out_slot_r;

  a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_EVAL)
    else $error("accepted request did not move to evaluation");

  a_desc_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    desc_we |-> (state_r == S_CLEAR || state_r == S_EVAL))
    else $error("descriptor write outside clear or evaluation");

  a_push_half: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && state_r == S_EVAL && req_func_r == FN_PUSH && res_status == STS_OK)
      |-> ((int'(push_idx) >= RING) == req_src_r))
    else $error("push landed in the wrong pool half");

  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_EVAL || $past(state_r) == S_PULL))
    else $error("result appeared without a finished request");

endmodule

// ===== design/ptdr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptdr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ptdr_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem_r[raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/ptdr_ptr_file.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptdr_ptr_file
// Reserve, receive and process pointers per thread, kept as offsets inside
// the thread's ring segment.
// ----------------------------------------------------------------------------
module ptdr_ptr_file
  import ptdr_pkg::*;
#(
  parameter int  THREADS          = 4,
  parameter int  SLOTS_PER_THREAD = 8,
  localparam int OFW              = $clog2(SLOTS_PER_THREAD)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [THREAD_W-1:0] rd_thread,
  input  func_t               rd_sel,
  output logic [OFW-1:0]      rd_off,
  input  ptr_cmd_t            cmd
);

  localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;

  logic [OFW-1:0] rsv_r [THREADS];
  logic [OFW-1:0] rcv_r [THREADS];
  logic [OFW-1:0] prc_r [THREADS];
  logic [TW-1:0]  ri;
  logic [TW-1:0]  wi;

  function automatic logic [OFW-1:0] wrap_inc(input logic [OFW-1:0] off);
    logic [OFW-1:0] res;
    if (off == OFW'(SLOTS_PER_THREAD - 1)) begin
      res = '0;
    end else begin
      res = off + 1'b1;
    end
    return res;
  endfunction

  assign ri = (int'(rd_thread) < THREADS) ? TW'(rd_thread) : '0;
  assign wi = (int'(cmd.thread) < THREADS) ? TW'(cmd.thread) : '0;

  always_comb begin
    case (rd_sel)
      FN_PUSH: rd_off = rcv_r[ri];
      FN_PULL: rd_off = prc_r[ri];
      default: rd_off = rsv_r[ri];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < THREADS; i++) begin
        rsv_r[i] <= '0;
        rcv_r[i] <= '0;
        prc_r[i] <= '0;
      end
    end else if (cmd.adv) begin
      case (cmd.sel)
        FN_RESERVE: rsv_r[wi] <= wrap_inc(rsv_r[wi]);
        FN_PUSH:    rcv_r[wi] <= wrap_inc(rcv_r[wi]);
        FN_PULL:    prc_r[wi] <= wrap_inc(prc_r[wi]);
        default: ;
      endcase
    end
  end

endmodule

// ===== dv/ptdr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptdr_checker
// Watches both channels of the descriptor ring. Each request transfer is run
// through a local copy of the ring and pool state. The result it predicts is
// queued, and each result transfer is compared with the oldest queued one.
// ----------------------------------------------------------------------------
module ptdr_checker
  import ptdr_pkg::*;
#(
  parameter int THREADS          = 4,
  parameter int SLOTS_PER_THREAD = 8,
  parameter int PAYLOAD_BITS     = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [1:0]          in_func,
  input  logic [THREAD_W-1:0] in_thread,
  input  logic                in_source,
  input  logic [LEN_W-1:0]    in_packet_len,
  input  logic [DATA_W-1:0]   in_packet_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [1:0]          out_status,
  input  logic [LEN_W-1:0]    out_len,
  input  logic [DATA_W-1:0]   out_data,
  input  logic [SLOT_W-1:0]   out_slot_used,
  output int                  errors,
  output int                  outstanding,
  output int                  pulled,
  output int                  rejected
);

  localparam int RING  = THREADS * SLOTS_PER_THREAD;
  localparam int POOL  = 2 * RING;
  localparam int PTR_W = $clog2(RING);
  localparam logic [DATA_W-1:0] PAYLOAD_MASK = {DATA_W{1'b1}} >> (DATA_W - PAYLOAD_BITS);

  typedef struct packed {
    logic [1:0]        status;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
    logic [SLOT_W-1:0] slot;
  } resp_t;

  dstate_t           desc_st   [RING];
  logic [SLOT_W-1:0] desc_slot [RING];
  logic [LEN_W-1:0]  slot_len  [POOL];
  logic [DATA_W-1:0] slot_data [POOL];
  logic [PTR_W-1:0]  rsv_ptr   [THREADS];
  logic [PTR_W-1:0]  rcv_ptr   [THREADS];
  logic [PTR_W-1:0]  prc_ptr   [THREADS];
  resp_t             resp_q[$];
  int                mism;

  // pointers wrap inside the thread's own segment
  function automatic logic [PTR_W-1:0] seg_next(logic [PTR_W-1:0] p, int t);
    int base;
    base = t * SLOTS_PER_THREAD;
    if (int'(p) - base >= SLOTS_PER_THREAD - 1) return PTR_W'(base);
    return p + 1'b1;
  endfunction

  function automatic resp_t ring_response(logic [1:0] fn, logic [THREAD_W-1:0] t,
                                          logic src, logic [LEN_W-1:0] len,
                                          logic [DATA_W-1:0] data);
    resp_t r;
    int tn, d, idx, hit, i;
    r = '0;
    r.status = STS_BAD_STATE;
    tn = int'(t);
    if (tn < THREADS) begin
      case (fn)
        FN_RESERVE: begin
          d = int'(rsv_ptr[tn]);
          if (desc_st[d] == DS_FREE) begin
            rsv_ptr[tn]  = seg_next(rsv_ptr[tn], tn);
            desc_st[d]   = DS_RESERVED;
            desc_slot[d] = '0;
            r.status     = STS_OK;
          end
        end
        FN_PUSH: begin
          d = int'(rcv_ptr[tn]);
          if (desc_st[d] == DS_RESERVED) begin
            hit = -1;
            // lowest empty slot of this thread's share of the chosen half
            for (i = 0; i < SLOTS_PER_THREAD; i++) begin
              idx = tn * SLOTS_PER_THREAD + i + (src ? RING : 0);
              if (hit < 0 && slot_len[idx] == '0) hit = idx;
            end
            if (hit >= 0) begin
              slot_len[hit]  = len;
              slot_data[hit] = data & PAYLOAD_MASK;
              rcv_ptr[tn]    = seg_next(rcv_ptr[tn], tn);
              desc_st[d]     = DS_FILLED;
              desc_slot[d]   = SLOT_W'(hit);
              r.status       = STS_OK;
              r.slot         = SLOT_W'(hit);
            end else begin
              r.status = STS_NO_SLOT;
            end
          end
        end
        FN_PULL: begin
          d = int'(prc_ptr[tn]);
          if (desc_st[d] == DS_FILLED) begin
            idx           = int'(desc_slot[d]);
            prc_ptr[tn]   = seg_next(prc_ptr[tn], tn);
            r.len         = slot_len[idx];
            r.data        = slot_data[idx];
            r.slot        = SLOT_W'(idx);
            slot_len[idx] = '0;
            desc_st[d]    = DS_FREE;
            r.status      = STS_OK;
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  always @(posedge clk) begin
    resp_t got, want;
    int i;
    if (!rst_n) begin
      for (i = 0; i < RING; i++) begin
        desc_st[i]   = DS_FREE;
        desc_slot[i] = '0;
      end
      for (i = 0; i < POOL; i++) begin
        slot_len[i]  = '0;
        slot_data[i] = '0;
      end
      for (i = 0; i < THREADS; i++) begin
        rsv_ptr[i] = PTR_W'(i * SLOTS_PER_THREAD);
        rcv_ptr[i] = PTR_W'(i * SLOTS_PER_THREAD);
        prc_ptr[i] = PTR_W'(i * SLOTS_PER_THREAD);
      end
      resp_q.delete();
      mism = 0;
      outstanding <= 0;
    end else begin
      // results first, so a result in the same cycle as a request is never
      // matched against that request
      if (out_valid && out_ready) begin
        got = {out_status, out_len, out_data, out_slot_used};
        if (resp_q.size() == 0) begin
          if (mism < 10)
            $display("%0t: result with none pending: status %0d len %h data %h slot %0d",
                     $time, got.status, got.len, got.data, got.slot);
          mism++;
        end else begin
          want = resp_q.pop_front();
          if (got != want) begin
            if (mism < 10)
              $display("%0t: result mismatch: exp status %0d len %h data %h slot %0d, got status %0d len %h data %h slot %0d",
                       $time, want.status, want.len, want.data, want.slot,
                       got.status, got.len, got.data, got.slot);
            mism++;
          end
        end
      end
      if (in_valid && in_ready) begin
        want = ring_response(in_func, in_thread, in_source, in_packet_len, in_packet_data);
        if (want.status != STS_OK) rejected <= rejected + 1;
        else if (in_func == FN_PULL) pulled <= pulled + 1;
        resp_q.push_back(want);
      end
      outstanding <= resp_q.size();
      errors      <= mism;
    end
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the per-thread descriptor ring. A short directed opening
// covers the edge cases. After it come random reserve/push/pull bursts per
// thread, with some arbitrary requests mixed in. Both sides idle at random.
// The checker beside the DUT predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import ptdr_pkg::*;

  localparam int THREADS = 4;
  localparam int SLOTS   = 8;
  localparam int ITEMS   = 650;
  localparam logic [1:0] FN_UNDEF = 2'd3;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          in_func;
  logic [THREAD_W-1:0] in_thread;
  logic                in_source;
  logic [LEN_W-1:0]    in_packet_len;
  logic [DATA_W-1:0]   in_packet_data;
  logic                out_valid;
  logic                out_ready;
  logic [1:0]          out_status;
  logic [LEN_W-1:0]    out_len;
  logic [DATA_W-1:0]   out_data;
  logic [SLOT_W-1:0]   out_slot_used;

  int errors, outstanding, pulled, rejected;
  int ops_sent;   // reserve/push/pull only
  int issued;
  bit calm;       // no idling on either side while set

  per_thread_descriptor_ring_top u_dut (.*);

  ptdr_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_req(input logic [1:0] fn, input int t, input logic src,
                          input logic [LEN_W-1:0] len, input logic [DATA_W-1:0] data);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= fn;
    in_thread      <= THREAD_W'(t);
    in_source      <= src;
    in_packet_len  <= len;
    in_packet_data <= data;
    do @(posedge clk); while (in_ready !== 1'b1);
    issued++;
    if (fn != FN_UNDEF) ops_sent++;
    @(negedge clk);
  endtask

  function automatic logic [LEN_W-1:0] pkt_len();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick < 2) return '0;
    if (pick == 2) return '1;
    return LEN_W'($urandom);
  endfunction

  // fields that the operation ignores still get random values
  task automatic send_any(input logic [1:0] fn, input int t);
    send_req(fn, t, 1'($urandom_range(0, 1)), pkt_len(), $urandom);
  endtask

  task automatic drain_hold();
    in_valid <= 1'b0;
    wait (outstanding == 0);
    @(negedge clk);
  endtask

  initial begin
    int t, n, k;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_func        = FN_RESERVE;
    in_thread      = '0;
    in_source      = 1'b0;
    in_packet_len  = '0;
    in_packet_data = '0;
    calm           = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // nothing reserved or filled yet
    send_req(FN_PULL, 0, 1'b0, '0, '0);
    send_req(FN_PUSH, 0, 1'b0, '0, '0);
    send_req(FN_UNDEF, 1, 1'b1, '1, '1);
    // basic round trip at full length and payload
    send_req(FN_RESERVE, 0, 1'b0, '0, '0);
    send_req(FN_PUSH, 0, 1'b0, '1, '1);
    send_req(FN_PULL, 0, 1'b0, '0, '0);
    // zero-length push leaves the slot free, so the next push reuses it
    send_req(FN_RESERVE, 1, 1'b0, '0, '0);
    send_req(FN_PUSH, 1, 1'b1, '0, 32'h1234_5678);
    send_req(FN_RESERVE, 1, 1'b0, '0, '0);
    send_req(FN_PUSH, 1, 1'b1, 16'h0001, 32'hA5A5_5A5A);
    send_req(FN_PULL, 1, 1'b0, '0, '0);
    send_req(FN_PULL, 1, 1'b0, '0, '0);
    // ninth reserve wraps onto a descriptor that is still reserved
    repeat (9) send_req(FN_RESERVE, 3, 1'b1, 16'h8000, 32'h8000_0000);
    send_req(FN_PULL, 3, 1'b0, '0, '0);
    send_req(FN_PUSH, 2, 1'b0, 16'h8000, 32'h8000_0000);
    drain_hold();

    while (ops_sent < ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 4))
          send_any(2'($urandom_range(0, 3)), $urandom_range(0, THREADS - 1));
      end else begin
        t = $urandom_range(0, THREADS - 1);
        n = $urandom_range(1, SLOTS);
        repeat (n) send_any(FN_RESERVE, t);
        repeat (n) send_any(FN_PUSH, t);
        // pull count varies so segments carry state from burst to burst
        k = $urandom_range(0, 2 * n);
        repeat (k) send_any(FN_PULL, t);
      end
      if ($urandom_range(0, 19) == 0) drain_hold();
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    wait (outstanding == 0);
    repeat (20) @(posedge clk);
    $display("Sent %0d requests (%0d reserve/push/pull) over all %0d threads.",
             issued, ops_sent, THREADS);
    $display("%0d pulls returned a packet; %0d requests were turned away.", pulled, rejected);
    if (errors == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // result side: one stall draw per transfer
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = calm ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  initial begin
    #2_000_000;
    $display("Timeout: %0d results still pending", outstanding);
    $display("Regression FAIL");
    $finish;
  end

endmodule
